// ===== design/utwm_pkg.sv =====
package utwm_pkg;

  localparam int unsigned CODE_BITS  = 21;
  localparam int unsigned WIDTH_BITS = 24;
  localparam int unsigned CFG_DATA_BITS = 21;
  localparam int unsigned CFG_INDEX_BITS = 2;

  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = 24'hFFFFFF;

  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD2_BITS  = 8'h1F;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD3_BITS  = 8'h0F;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_CODE  = 8'hF0;
  localparam logic [7:0] LEAD4_BITS  = 8'h07;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_CODE   = 8'h80;
  localparam logic [7:0] CONT_BITS   = 8'h3F;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FIRST_CODE     = 2'd0,
    CFG_LAST_CODE      = 2'd1,
    CFG_LETTER_SPACING = 2'd2
  } cfg_index_t;

  typedef enum logic [0:0] {
    CMD_TABLE_WRITE = 1'b0,
    CMD_TEXT_BYTE   = 1'b1
  } command_t;

  // Outcome of decoding the head of the pending byte buffer
  typedef struct packed {
    logic                 done;      // nothing more to decode now
    logic                 line_end;  // CR or LF in lead position
    logic [CODE_BITS-1:0] code;      // codepoint to measure when not done
    logic [2:0]           drop;      // bytes consumed by this codepoint
  } decode_t;

endpackage

// ===== design/utwm_in_if.sv =====
interface utwm_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] text_byte;
  logic       end_of_text;
  logic [6:0] entry_index;
  logic [7:0] entry_advance;

  modport source(output valid, command, text_byte, end_of_text, entry_index, entry_advance,
                 input ready);
  modport sink(input valid, command, text_byte, end_of_text, entry_index, entry_advance,
               output ready);
endinterface

// ===== design/utwm_out_if.sv =====
interface utwm_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] text_width;
  logic        width_saturated;

  modport source(output valid, text_width, width_saturated, input ready);
  modport sink(input valid, text_width, width_saturated, output ready);
endinterface

// ===== design/utf8_text_width_measure_core.sv =====
// UTF-8 text width measurement core.
// text_in takes requests: command 0 writes one glyph advance entry, command 1 gives
// one text byte, with end_of_text on the last byte. result_out carries one request
// per text: the pixel width up to the first CR or LF and a saturation flag.
// Configuration (first_code, last_code, letter_spacing) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the core is idle,
// as the core does not enforce this. Every glyph that a text byte releases goes
// through decode, table lookup and accumulate (through the single shared adder),
// while a glyph that is skipped goes through decode and table lookup only; a bad
// sequence replays up to four bytes. The byte that ends the text then passes to
// the done state to hand its result over. After the last glyph of the text is
// accumulated, the core goes through decode and done before the result is loaded
// into the output register.
// text_in.ready is low while a byte is being worked on. A finished result waits in
// the output register; the next text can start meanwhile, and the core holds in
// its final step only if a second result is ready before the first was taken.
// Reset (rst, synchronous) clears the text state and loads the default range
// 32..126 with zero spacing. The advance table is not cleared: every entry
// must be written before a text uses it.
module utf8_text_width_measure_core #(
  parameter int unsigned GLYPH_COUNT  = 128,
  parameter int unsigned ADVANCE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [utwm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [utwm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  utwm_in_if.sink                             text_in,
  utwm_out_if.source                          result_out
);

  localparam int unsigned AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int unsigned CB = utwm_pkg::CODE_BITS;
  localparam int unsigned WB = utwm_pkg::WIDTH_BITS;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_ACCUM  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state;

  logic [CB-1:0] first_code;
  logic [CB-1:0] last_code;
  logic [7:0]    letter_spacing;

  logic [7:0]    pend [4];
  logic [2:0]    count;
  logic          line_ended;
  logic          first_glyph;
  logic [WB-1:0] width_sum;
  logic          sum_clamped;
  logic          eot;
  logic [CB-1:0] code;

  logic          out_valid;
  logic [WB-1:0] out_width;
  logic          out_sat;

  utwm_pkg::decode_t dec;

  logic                    in_fire;
  logic                    tbl_we;
  logic [ADVANCE_BITS-1:0] rdata;
  logic                    code_ok;
  logic                    qmark_ok;
  logic [CB-1:0]           use_code;
  logic [CB:0]             idx;
  logic                    glyph_ok;
  logic [6:0]              tracking;
  logic [WB+1:0]           sum_wide;
  logic                    load_out;

  assign text_in.ready = (state == ST_IDLE);
  assign in_fire       = text_in.valid && text_in.ready;
  assign tbl_we        = in_fire && (text_in.command == utwm_pkg::CMD_TABLE_WRITE) &&
                         (32'(text_in.entry_index) < GLYPH_COUNT);

  utwm_decode u_decode (
    .pend  (pend),
    .count (count),
    .eot   (eot),
    .dec   (dec)
  );

  // range check with the question mark as fallback glyph
  assign code_ok  = (code >= first_code) && (code <= last_code);
  assign qmark_ok = (CB'(utwm_pkg::CHAR_QMARK) >= first_code) &&
                    (CB'(utwm_pkg::CHAR_QMARK) <= last_code);
  assign use_code = code_ok ? code : CB'(utwm_pkg::CHAR_QMARK);
  assign idx      = {1'b0, use_code} - {1'b0, first_code};
  assign glyph_ok = (code_ok || qmark_ok) && (32'(idx) < GLYPH_COUNT);

  utwm_table #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .ADVANCE_BITS (ADVANCE_BITS),
    .AW           (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(text_in.entry_index)),
    .wdata (ADVANCE_BITS'(text_in.entry_advance)),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign tracking = (first_glyph || letter_spacing[7]) ? 7'd0 : letter_spacing[6:0];
  assign sum_wide = (WB+2)'(width_sum) + (WB+2)'(tracking) + (WB+2)'(rdata);
  assign load_out = (state == ST_DONE) && (!out_valid || result_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code     <= CB'(32);
      last_code      <= CB'(126);
      letter_spacing <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        utwm_pkg::CFG_FIRST_CODE:     first_code     <= cfg_data;
        utwm_pkg::CFG_LAST_CODE:      last_code      <= cfg_data;
        utwm_pkg::CFG_LETTER_SPACING: letter_spacing <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= 3'd0;
      line_ended  <= 1'b0;
      first_glyph <= 1'b1;
      width_sum   <= '0;
      sum_clamped <= 1'b0;
      eot         <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && text_in.command == utwm_pkg::CMD_TEXT_BYTE) begin
            eot <= text_in.end_of_text;
            if (!line_ended && count < 3'd4) begin
              pend[count[1:0]] <= text_in.text_byte;
              count            <= count + 3'd1;
            end
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (line_ended || dec.done) begin
            if (dec.line_end && !line_ended) begin
              line_ended <= 1'b1;
            end
            if (line_ended || dec.line_end) begin
              count <= 3'd0;
            end
            state <= eot ? ST_DONE : ST_IDLE;
          end else begin
            code <= dec.code;
            // drop the consumed bytes from the front
            for (int i = 0; i < 4; i++) begin
              if (3'(i) + dec.drop < 3'd4) begin
                pend[i] <= pend[2'(3'(i) + dec.drop)];
              end
            end
            count <= (dec.drop >= count) ? 3'd0 : count - dec.drop;
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state <= glyph_ok ? ST_ACCUM : ST_DECODE;
        end
        ST_ACCUM: begin
          if (sum_wide > (WB+2)'(utwm_pkg::WIDTH_MAX)) begin
            width_sum   <= utwm_pkg::WIDTH_MAX;
            sum_clamped <= 1'b1;
          end else begin
            width_sum <= sum_wide[WB-1:0];
          end
          first_glyph <= 1'b0;
          state       <= ST_DECODE;
        end
        ST_DONE: begin
          if (load_out) begin
            count       <= 3'd0;
            line_ended  <= 1'b0;
            first_glyph <= 1'b1;
            width_sum   <= '0;
            sum_clamped <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_width <= width_sum;
      out_sat   <= sum_clamped;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.text_width      = out_width;
  assign result_out.width_saturated = out_sat;

endmodule

// ===== design/utwm_decode.sv =====
module utwm_decode (
  input  logic [7:0]       pend [4],
  input  logic [2:0]       count,
  input  logic             eot,
  output utwm_pkg::decode_t dec
);

  logic [7:0]                      lead;
  logic                            multi;
  logic                            bad;
  logic [2:0]                      cont;
  logic [2:0]                      avail;
  logic [utwm_pkg::CODE_BITS-1:0]  acc;

  assign lead = pend[0];

  always_comb begin
    dec.done     = 1'b0;
    dec.line_end = 1'b0;
    dec.code     = utwm_pkg::CODE_BITS'(utwm_pkg::CHAR_QMARK);
    dec.drop     = 3'd1;
    multi        = 1'b0;
    bad          = 1'b0;
    cont         = 3'd0;
    acc          = '0;
    avail        = count - 3'd1;

    if (count == 3'd0) begin
      dec.done = 1'b1;
    end else if (lead == utwm_pkg::CHAR_CR || lead == utwm_pkg::CHAR_LF) begin
      dec.line_end = 1'b1;
      dec.done     = 1'b1;
    end else if (lead < utwm_pkg::ASCII_LIMIT) begin
      dec.code = utwm_pkg::CODE_BITS'(lead);
    end else if ((lead & utwm_pkg::LEAD2_MASK) == utwm_pkg::LEAD2_CODE) begin
      multi = 1'b1;
      cont  = 3'd1;
      acc   = utwm_pkg::CODE_BITS'(lead & utwm_pkg::LEAD2_BITS);
    end else if ((lead & utwm_pkg::LEAD3_MASK) == utwm_pkg::LEAD3_CODE) begin
      multi = 1'b1;
      cont  = 3'd2;
      acc   = utwm_pkg::CODE_BITS'(lead & utwm_pkg::LEAD3_BITS);
    end else if ((lead & utwm_pkg::LEAD4_MASK) == utwm_pkg::LEAD4_CODE) begin
      multi = 1'b1;
      cont  = 3'd3;
      acc   = utwm_pkg::CODE_BITS'(lead & utwm_pkg::LEAD4_BITS);
    end

    if (multi) begin
      // walk the continuation bytes on hand, stop at the first bad one
      for (int i = 1; i < 4; i++) begin
        if (!bad && 3'(i) <= cont && 3'(i) <= avail) begin
          if ((pend[i] & utwm_pkg::CONT_MASK) != utwm_pkg::CONT_CODE) begin
            bad = 1'b1;
          end else begin
            acc = {acc[utwm_pkg::CODE_BITS-7:0], 6'(pend[i] & utwm_pkg::CONT_BITS)};
          end
        end
      end
      if (bad) begin
        dec.drop = 3'd1;
      end else if (avail < cont) begin
        // incomplete: replace the lead at end of text, otherwise wait for more
        if (!eot) begin
          dec.done = 1'b1;
        end
      end else begin
        dec.code = acc;
        dec.drop = cont + 3'd1;
      end
    end
  end

endmodule

// ===== design/utwm_table.sv =====
module utwm_table #(
  parameter int unsigned GLYPH_COUNT  = 128,
  parameter int unsigned ADVANCE_BITS = 8,
  parameter int unsigned AW           = 7
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [ADVANCE_BITS-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic [ADVANCE_BITS-1:0] rdata
);

  logic [ADVANCE_BITS-1:0] mem [GLYPH_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
